/* hw/rtl/bti_pkg.sv */
`default_nettype none
package bti_pkg;

    // Data format: signed Q16.16
    localparam int DATA_WIDTH       = 32;
    localparam int MAX_AXIS_ONE_DEF = 16;
    localparam int MAX_AXIS_TWO_DEF = 16;
    localparam int CFG_WIDTH        = 5;
    localparam int CFG_IDX_WIDTH    = 2;
    localparam int ENTRY_IDX_WIDTH  = 8;

    // Input item commands
    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_WR_AX1 = 2'd1,
        CMD_WR_AX2 = 2'd2,
        CMD_WR_GRD = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_AXIS_ONE_POINTS = 2'd0,
        CFG_AXIS_TWO_POINTS = 2'd1,
        CFG_UNUSED_2        = 2'd2,
        CFG_UNUSED_3        = 2'd3
    } t_cfg_idx;

    // Top level sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH1,
        S_SRCH2,
        S_GRD0,
        S_GRD1,
        S_GRD2,
        S_ROWW,
        S_COLW,
        S_DONE
    } t_state;

    // Shared interpolation unit
    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_DONE
    } t_lerp_state;

endpackage
`default_nettype wire

/* hw/rtl/bilinear_table_interpolator_top.sv */
`default_nettype none
// Bilinear table interpolator.
// Input channel (i_in_valid/o_in_ready) carries one item: a load command
// writing an axis point or grid value, or a query with two Q16.16 coords.
// Load items give no result. A query gives one result
// item on the output channel (o_out_valid/i_out_ready).
// A query runs search one over axis one, then search two over axis two,
// then per grid row a registered grid read; an edge column takes the value
// as read, else a second read and a blend in the shared multiply/divide
// unit. With two rows a final blend across rows follows in the same unit,
// then the output register is loaded. The divide steps of the shared
// unit, one quotient bit a cycle, dominate. One item is in work at a time.
// The configuration port (always ready) sets point counts; write it only
// while idle. Reset clears control and sets both counts to 16;
// tables are undefined until loaded.
// A finished result sits in an output register; the block returns to
// idle and takes load items while the receiver stalls, and holds a new
// result back until the previous one is taken.
module bilinear_table_interpolator_top #(
    parameter int MAX_AXIS_ONE = bti_pkg::MAX_AXIS_ONE_DEF,
    parameter int MAX_AXIS_TWO = bti_pkg::MAX_AXIS_TWO_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    output logic                                            o_in_ready,
    input  wire logic [1:0]                                 i_cmd,
    input  wire logic [bti_pkg::ENTRY_IDX_WIDTH-1:0]        i_entry_index,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0]      i_entry_value,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0]      i_query_x1,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0]      i_query_x2,
    output logic                                            o_out_valid,
    input  wire logic                                       i_out_ready,
    output logic signed [bti_pkg::DATA_WIDTH-1:0]           o_interpolated_value,
    input  wire logic                                       i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  wire logic [bti_pkg::CFG_IDX_WIDTH-1:0]          i_cfg_index,
    input  wire logic [bti_pkg::CFG_WIDTH-1:0]              i_cfg_data
);
    import bti_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int CW1   = $clog2(MAX_AXIS_ONE + 1);
    localparam int CW2   = $clog2(MAX_AXIS_TWO + 1);
    localparam int IW1   = $clog2(MAX_AXIS_ONE);
    localparam int IW2   = $clog2(MAX_AXIS_TWO);
    localparam int GDEP  = MAX_AXIS_ONE * MAX_AXIS_TWO;
    localparam int GA    = $clog2(GDEP);

    // storage
    logic signed [DW-1:0] r_axis1 [MAX_AXIS_ONE];
    logic signed [DW-1:0] r_axis2 [MAX_AXIS_TWO];
    logic signed [DW-1:0] r_grid  [GDEP];
    logic signed [DW-1:0] r_gdata;

    logic [CFG_WIDTH-1:0] r_cfg1, r_cfg2;
    logic [CW1-1:0]       w_n1;
    logic [CW2-1:0]       w_n2;

    t_state r_state, n_state;

    logic signed [DW-1:0] r_x1, r_x2, r_prev, r_alo, r_ahi, r_blo, r_bhi;
    logic signed [DW-1:0] r_glo, r_z1, r_res;
    logic [CW1-1:0]       r_k1;
    logic [CW2-1:0]       r_k2;
    logic [IW1-1:0]       r_row;
    logic [IW2-1:0]       r_col_lo, r_col_hi;
    logic                 r_two, r_second, r_col_edge;
    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_data;

    logic signed [DW-1:0] w_a1v, w_a2v, w_z;
    logic                 w_step1, w_step2, w_row_done, w_accept, w_emit;
    logic [GA-1:0]        w_base, w_raddr;

    logic                 w_lstart;
    logic signed [DW-1:0] w_llow, w_lhigh, w_lx, w_la0, w_la1, w_lres;
    logic                 w_ldone;

    // effective point counts
    always_comb begin
        if (r_cfg1 == '0)                             w_n1 = CW1'(1);
        else if (32'(r_cfg1) > MAX_AXIS_ONE)          w_n1 = CW1'(MAX_AXIS_ONE);
        else                                          w_n1 = CW1'(r_cfg1);
        if (r_cfg2 == '0)                             w_n2 = CW2'(1);
        else if (32'(r_cfg2) > MAX_AXIS_TWO)          w_n2 = CW2'(MAX_AXIS_TWO);
        else                                          w_n2 = CW2'(r_cfg2);
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg1 <= CFG_WIDTH'(16);
            r_cfg2 <= CFG_WIDTH'(16);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_AXIS_ONE_POINTS: r_cfg1 <= i_cfg_data;
                CFG_AXIS_TWO_POINTS: r_cfg2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // axis tables: loaded from input items, read at the search counter
    always_ff @(posedge i_clk) begin
        if (w_accept && t_cmd'(i_cmd) == CMD_WR_AX1 && 32'(i_entry_index) < MAX_AXIS_ONE)
            r_axis1[IW1'(i_entry_index)] <= i_entry_value;
        if (w_accept && t_cmd'(i_cmd) == CMD_WR_AX2 && 32'(i_entry_index) < MAX_AXIS_TWO)
            r_axis2[IW2'(i_entry_index)] <= i_entry_value;
    end

    assign w_a1v = r_axis1[r_k1[IW1-1:0]];
    assign w_a2v = r_axis2[r_k2[IW2-1:0]];
    assign w_step1 = (r_k1 < w_n1) && (r_x1 > w_a1v);
    assign w_step2 = (r_k2 < w_n2) && (r_x2 > w_a2v);

    // grid memory, one write and one registered read port
    assign w_base  = GA'(r_row) * GA'(MAX_AXIS_TWO);
    assign w_raddr = (r_state == S_GRD0) ? (w_base + GA'(r_col_lo))
                                         : (w_base + GA'(r_col_hi));
    always_ff @(posedge i_clk) begin
        if (w_accept && t_cmd'(i_cmd) == CMD_WR_GRD && 32'(i_entry_index) < GDEP)
            r_grid[GA'(i_entry_index)] <= i_entry_value;
        r_gdata <= r_grid[w_raddr];
    end

    // row value ready: edge column straight from memory, else from the unit
    assign w_z        = (r_state == S_GRD1) ? r_gdata : w_lres;
    assign w_row_done = ((r_state == S_GRD1) && r_col_edge) ||
                        ((r_state == S_ROWW) && w_ldone);
    assign w_emit     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // shared unit operand select
    always_comb begin
        w_lstart = 1'b0;
        w_llow   = r_glo;
        w_lhigh  = r_gdata;
        w_lx     = r_x2;
        w_la0    = r_blo;
        w_la1    = r_bhi;
        if (r_state == S_GRD2) begin
            w_lstart = 1'b1;
        end else if (w_row_done && r_two && r_second) begin
            w_lstart = 1'b1;
            w_llow   = r_z1;
            w_lhigh  = w_z;
            w_lx     = r_x1;
            w_la0    = r_alo;
            w_la1    = r_ahi;
        end
    end

    bti_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_lstart),
        .i_low    (w_llow),
        .i_high   (w_lhigh),
        .i_x      (w_lx),
        .i_a0     (w_la0),
        .i_a1     (w_la1),
        .o_done   (w_ldone),
        .o_result (w_lres)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept && t_cmd'(i_cmd) == CMD_QUERY) n_state = S_SRCH1;
            S_SRCH1: if (!w_step1) n_state = S_SRCH2;
            S_SRCH2: if (!w_step2) n_state = S_GRD0;
            S_GRD0:  n_state = S_GRD1;
            S_GRD1: begin
                if (!r_col_edge)                 n_state = S_GRD2;
                else if (r_two && !r_second)     n_state = S_GRD0;
                else if (r_two)                  n_state = S_COLW;
                else                             n_state = S_DONE;
            end
            S_GRD2:  n_state = S_ROWW;
            S_ROWW: begin
                if (w_ldone) begin
                    if (r_two && !r_second)      n_state = S_GRD0;
                    else if (r_two)              n_state = S_COLW;
                    else                         n_state = S_DONE;
                end
            end
            S_COLW:  if (w_ldone) n_state = S_DONE;
            S_DONE:  if (w_emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x1     <= i_query_x1;
                r_x2     <= i_query_x2;
                r_k1     <= '0;
                r_second <= 1'b0;
            end
            S_SRCH1: begin
                if (w_step1) begin
                    r_prev <= w_a1v;
                    r_k1   <= r_k1 + 1'b1;
                end else begin
                    r_alo <= r_prev;
                    r_ahi <= w_a1v;
                    r_k2  <= '0;
                    r_two <= (r_k1 != '0) && (r_k1 < w_n1);
                    if (r_k1 == '0)       r_row <= '0;
                    else if (r_k1 >= w_n1) r_row <= IW1'(w_n1 - 1'b1);
                    else                  r_row <= IW1'(r_k1 - 1'b1);
                end
            end
            S_SRCH2: begin
                if (w_step2) begin
                    r_prev <= w_a2v;
                    r_k2   <= r_k2 + 1'b1;
                end else begin
                    r_blo      <= r_prev;
                    r_bhi      <= w_a2v;
                    r_col_edge <= (r_k2 == '0) || (r_k2 >= w_n2);
                    r_col_hi   <= IW2'(r_k2);
                    if (r_k2 == '0)        r_col_lo <= '0;
                    else if (r_k2 >= w_n2) r_col_lo <= IW2'(w_n2 - 1'b1);
                    else                   r_col_lo <= IW2'(r_k2 - 1'b1);
                end
            end
            S_GRD1: r_glo <= r_gdata;
            S_COLW: if (w_ldone) r_res <= w_lres;
            default: ;
        endcase
        // row finished: keep first row, or take single-row result
        if (w_row_done) begin
            if (r_two && !r_second) begin
                r_z1     <= w_z;
                r_second <= 1'b1;
                r_row    <= r_row + 1'b1;
            end else if (!r_two) begin
                r_res <= w_z;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) r_out_data <= r_res;
    end

    assign o_out_valid          = r_out_valid;
    assign o_interpolated_value = r_out_data;

endmodule
`default_nettype wire

/* hw/rtl/bti_lerp.sv */
`default_nettype none
// low + (high - low) * (x - a0) / (a1 - a0), truncated toward zero.
// A multiply step, then one restoring divide step per cycle.
// A new start is taken in the idle cycle or in the done cycle.
module bti_lerp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0] i_low,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0] i_high,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0] i_x,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0] i_a0,
    input  wire logic signed [bti_pkg::DATA_WIDTH-1:0] i_a1,
    output logic                                       o_done,
    output logic signed [bti_pkg::DATA_WIDTH-1:0]      o_result
);
    import bti_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int CNTW = $clog2(DW);

    t_lerp_state r_state, n_state;

    logic signed [DW:0]  w_diff;
    logic [DW-1:0]       r_mag, r_off, r_span, r_rem, r_q;
    logic                r_neg;
    logic signed [DW-1:0] r_low;
    logic [2*DW-1:0]     w_prod;
    logic [DW:0]         w_trial;
    logic                w_ge;
    logic [CNTW-1:0]     r_cnt;

    assign w_diff  = {i_high[DW-1], i_high} - {i_low[DW-1], i_low};
    assign w_prod  = r_mag * r_off;
    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_span});

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: if (i_start) n_state = L_MUL;
            L_MUL:  n_state = L_DIV;
            L_DIV:  if (r_cnt == CNTW'(DW - 1)) n_state = L_DONE;
            L_DONE: n_state = i_start ? L_MUL : L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE, L_DONE: begin
                if (i_start) begin
                    r_neg  <= w_diff[DW];
                    r_mag  <= w_diff[DW] ? DW'(-w_diff) : DW'(w_diff);
                    r_off  <= DW'(i_x - i_a0);
                    r_span <= DW'(i_a1 - i_a0);
                    r_low  <= i_low;
                end
            end
            L_MUL: begin
                // quotient fits DW bits, so the high half is below the span
                r_rem <= w_prod[2*DW-1:DW];
                r_q   <= w_prod[DW-1:0];
                r_cnt <= '0;
            end
            L_DIV: begin
                r_rem <= w_ge ? DW'(w_trial - {1'b0, r_span}) : w_trial[DW-1:0];
                r_q   <= {r_q[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done   = (r_state == L_DONE);
    assign o_result = r_neg ? (r_low - $signed(r_q)) : (r_low + $signed(r_q));

endmodule
`default_nettype wire

/* sim/tb_bilinear_table_interpolator_top.sv */
module tb_bilinear_table_interpolator_top;
    import bti_pkg::*;

    localparam int NPTS   = 16;
    localparam int SETTLE = 300;

    typedef struct {
        t_cmd        cmd;
        logic [7:0]  idx;
        logic [31:0] val;
        logic [31:0] x1;
        logic [31:0] x2;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = 2'd0;
    logic [7:0]  i_entry_index = 8'd0;
    logic signed [31:0] i_entry_value = '0;
    logic signed [31:0] i_query_x1 = '0;
    logic signed [31:0] i_query_x2 = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [31:0] o_interpolated_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [4:0]  i_cfg_data = 5'd0;

    bilinear_table_interpolator_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_entry_index(i_entry_index), .i_entry_value(i_entry_value),
        .i_query_x1(i_query_x1), .i_query_x2(i_query_x2),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_interpolated_value(o_interpolated_value),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // pending items, expected interpolated values
    t_item       pending_items[$];
    logic [31:0] expected_values[$];

    // predictor state
    longint      ax1_tab[NPTS];
    longint      ax2_tab[NPTS];
    longint      grid_tab[NPTS*NPTS];
    logic [4:0]  ax1_count = 5'd16;
    logic [4:0]  ax2_count = 5'd16;

    // axes as planned by the stimulus (used only to aim coordinates)
    longint      plan_ax1[NPTS];
    longint      plan_ax2[NPTS];

    int  n_errors = 0;
    int  n_queries = 0;
    int  n_loads = 0;
    int  n_checked = 0;
    int  n_cfg = 0;
    bit  sender_hold = 1'b0;
    int  rx_long_hold = 0;

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic int clip_count(logic [4:0] r);
        if (r == 0) return 1;
        if (r > NPTS) return NPTS;
        return int'(r);
    endfunction

    // lo + (hi - lo) * (x - a0) / (a1 - a0), truncated toward zero
    function automatic longint blend(longint lo, longint hi, longint x, longint a0,
                                     longint a1);
        longint diff;
        longint unsigned off, span, mag, q;
        diff = hi - lo;
        off  = longint'(x - a0);
        span = longint'(a1 - a0);
        if (span == 0) return lo;
        mag = (diff < 0) ? longint'(-diff) : diff;
        q   = (mag * off) / span;
        return (diff < 0) ? lo - longint'(q) : lo + longint'(q);
    endfunction

    function automatic int find_point(bit second, int n, longint x);
        int k;
        k = 0;
        while (k < n && x > (second ? ax2_tab[k] : ax1_tab[k])) k++;
        return k;
    endfunction

    function automatic longint row_blend(int row, int j, int n2, longint x2);
        int b;
        b = row * NPTS;
        if (j == 0) return grid_tab[b];
        if (j >= n2) return grid_tab[b + n2 - 1];
        return blend(grid_tab[b + j - 1], grid_tab[b + j], x2, ax2_tab[j - 1], ax2_tab[j]);
    endfunction

    // apply one accepted item to the table copy, queue the expected value
    function automatic void apply_item(t_item it);
        int n1, n2, i, j;
        longint x1, x2, r, z1, z2;
        case (it.cmd)
            CMD_WR_AX1: if (it.idx < NPTS) ax1_tab[it.idx] = sx32(it.val);
            CMD_WR_AX2: if (it.idx < NPTS) ax2_tab[it.idx] = sx32(it.val);
            CMD_WR_GRD: grid_tab[it.idx] = sx32(it.val);
            default: begin
                n1 = clip_count(ax1_count);
                n2 = clip_count(ax2_count);
                x1 = sx32(it.x1);
                x2 = sx32(it.x2);
                i = find_point(1'b0, n1, x1);
                j = find_point(1'b1, n2, x2);
                if (i == 0) r = row_blend(0, j, n2, x2);
                else if (i >= n1) r = row_blend(n1 - 1, j, n2, x2);
                else begin
                    z1 = row_blend(i - 1, j, n2, x2);
                    z2 = row_blend(i, j, n2, x2);
                    r = blend(z1, z2, x1, ax1_tab[i - 1], ax1_tab[i]);
                end
                expected_values = {expected_values, r[31:0]};
            end
        endcase
    endfunction

    // sender: bursts and gaps, fed from pending_items
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_item it;
        bit    taken;
        taken = i_in_valid && o_in_ready;
        if (taken) begin
            it.cmd = t_cmd'(i_cmd);
            it.idx = i_entry_index;
            it.val = i_entry_value;
            it.x1  = i_query_x1;
            it.x2  = i_query_x2;
            apply_item(it);
            if (it.cmd == CMD_QUERY) n_queries++;
            else n_loads++;
        end
        if (!i_in_valid || taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (!sender_hold && pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_cmd         <= it.cmd;
                i_entry_index <= it.idx;
                i_entry_value <= it.val;
                i_query_x1    <= it.x1;
                i_query_x2    <= it.x2;
                i_in_valid    <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 20);
                    gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: randomly chosen stall patterns, plus long holds
    int rx_phase = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (expected_values.size() == 0) begin
                $error("unexpected item: interpolated_value actual %0d",
                       o_interpolated_value);
                n_errors++;
            end else begin
                logic [31:0] e;
                e = expected_values.pop_front();
                n_checked++;
                if (e !== o_interpolated_value) begin
                    $error("interpolated_value mismatch: expected %0d actual %0d",
                           $signed(e), o_interpolated_value);
                    n_errors++;
                end
            end
        end
        rx_phase++;
        if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (rx_long_hold > 0) begin
            rx_long_hold--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 0);
                2: i_out_ready <= ($urandom_range(0, 4) == 0);
                default: i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic void push_load(t_cmd c, int idx, longint v);
        t_item it;
        it.cmd = c;
        it.idx = idx[7:0];
        it.val = v[31:0];
        it.x1  = $urandom;
        it.x2  = $urandom;
        pending_items = {pending_items, it};
        if (c == CMD_WR_AX1 && idx < NPTS) plan_ax1[idx] = sx32(v[31:0]);
        if (c == CMD_WR_AX2 && idx < NPTS) plan_ax2[idx] = sx32(v[31:0]);
    endfunction

    function automatic void push_query(longint x1, longint x2);
        t_item it;
        it.cmd = CMD_QUERY;
        it.idx = 8'($urandom);
        it.val = $urandom;
        it.x1  = x1[31:0];
        it.x2  = x2[31:0];
        pending_items = {pending_items, it};
    endfunction

    // reload one axis: wide full-range, narrow ascending, or scrambled
    function automatic void load_axis(t_cmd c, int shape);
        longint v, base;
        base = longint'(signed'($urandom_range(0, 2097152))) - 1048576;
        for (int k = 0; k < NPTS; k++) begin
            case (shape)
                0: v = (k == 0) ? -64'sd2147483648 : (k == NPTS - 1) ? 64'sd2147483647
                       : -64'sd2147483648 + k * 64'sd268435455 + $urandom_range(0, 1000);
                1: begin
                    base = base + $urandom_range(1, 262144);
                    v = base;
                end
                default: v = sx32($urandom);
            endcase
            push_load(c, k, v);
        end
    endfunction

    function automatic void load_grid(bit wide);
        for (int g = 0; g < NPTS * NPTS; g++)
            push_load(CMD_WR_GRD, g, wide ? sx32($urandom)
                      : longint'($urandom_range(0, 1 << 24)) - (1 << 23));
    endfunction

    function automatic longint aim(bit second);
        longint a0, a1, lo, hi, x;
        int k;
        k  = $urandom_range(0, NPTS - 1);
        a0 = second ? plan_ax2[0] : plan_ax1[0];
        a1 = second ? plan_ax2[NPTS - 1] : plan_ax1[NPTS - 1];
        case ($urandom_range(0, 9))
            0: return sx32($urandom);
            1: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            2: return second ? plan_ax2[k] : plan_ax1[k];
            3: return (second ? plan_ax2[k] : plan_ax1[k]) + $urandom_range(0, 2) - 1;
            default: begin
                lo = (a0 < a1 ? a0 : a1) - 70000;
                hi = (a0 < a1 ? a1 : a0) + 70000;
                x  = lo + (((hi - lo) * longint'($urandom)) >>> 32);
                if (x > 64'sd2147483647) x = 64'sd2147483647;
                if (x < -64'sd2147483648) x = -64'sd2147483648;
                return x;
            end
        endcase
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || i_in_valid || expected_values.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx r, logic [4:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (r == CFG_AXIS_ONE_POINTS) ax1_count = d;
        if (r == CFG_AXIS_TWO_POINTS) ax2_count = d;
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [4:0] c1[8] = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd16, 5'd2, 5'd31, 5'd9};
        logic [4:0] c2[8] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd1, 5'd16, 5'd0, 5'd12};
        int sel;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every table entry before any query
        load_axis(CMD_WR_AX1, 1);
        load_axis(CMD_WR_AX2, 1);
        load_grid(1'b1);
        // directed: extremes, exact points, out-of-range loads
        push_query(-64'sd2147483648, -64'sd2147483648);
        push_query(64'sd2147483647, 64'sd2147483647);
        push_query(-64'sd2147483648, 64'sd2147483647);
        push_query(plan_ax1[0], plan_ax2[0]);
        push_query(plan_ax1[NPTS - 1], plan_ax2[NPTS - 1]);
        push_query(plan_ax1[3] + 1, plan_ax2[7] - 1);
        push_query(plan_ax1[8], plan_ax2[8] + 1);
        push_load(CMD_WR_AX1, 16, 0);
        push_load(CMD_WR_AX2, 255, 0);
        push_load(CMD_WR_GRD, 255, 64'sd2147483647);
        push_load(CMD_WR_GRD, 0, -64'sd2147483648);
        push_query(-64'sd2147483648, 64'sd2147483647);
        push_query(64'sd2147483647, -64'sd2147483648);
        load_axis(CMD_WR_AX1, 0);
        push_query(0, plan_ax2[5]);
        push_query(plan_ax1[15] - 1, plan_ax2[1] + 1);
        wait_idle();
        write_cfg(CFG_UNUSED_2, 5'd7);
        write_cfg(CFG_UNUSED_3, 5'd31);

        for (int ph = 0; ph < 8; ph++) begin
            write_cfg(CFG_AXIS_ONE_POINTS, c1[ph]);
            write_cfg(CFG_AXIS_TWO_POINTS, c2[ph]);
            for (int n = 0; n < 120; n++) begin
                sel = $urandom_range(0, 99);
                // one full grid reload with narrow values mid-run
                if (ph == 4 && n == 60) load_grid(1'b0);
                if (sel < 82) push_query(aim(1'b0), aim(1'b1));
                else if (sel < 92)
                    push_load(CMD_WR_GRD, $urandom_range(0, 255), sx32($urandom));
                else if (sel < 96)
                    push_load($urandom_range(0, 1) ? CMD_WR_AX1 : CMD_WR_AX2,
                              $urandom_range(0, 31), sx32($urandom));
                else if (sel < 98)
                    load_axis($urandom_range(0, 1) ? CMD_WR_AX1 : CMD_WR_AX2,
                              $urandom_range(0, 7) == 0 ? 2 : $urandom_range(0, 1));
                else push_query(sx32($urandom), sx32($urandom));
                if (ph == 1 && n == 20) rx_long_hold = 800;
            end
            if (ph == 3) begin
                // sender pauses mid-phase until every result is back
                repeat (200) @(posedge i_clk);
                sender_hold = 1'b1;
                while (i_in_valid || expected_values.size() > 0) @(posedge i_clk);
                sender_hold = 1'b0;
            end
            wait_idle();
        end

        $display("covered %0d queries, %0d load items, %0d config writes", n_queries,
                 n_loads, n_cfg);
        $display("checked %0d interpolated results, %0d errors", n_checked, n_errors);
        if (n_errors == 0 && expected_values.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
